>>> design/assert_macros.svh
// Assertion macros shared by the rank-addressed byte vector RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RBV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RBV_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

>>> design/rbv_pkg.sv
// Types and constants for the rank-addressed byte vector.
// No dependencies; imported by every module of the block.
package rbv_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned RANK_W    = 7;
	localparam int unsigned DATA_W    = 8;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned CNT_W     = 7;

	typedef enum logic [OP_W-1:0] {
		OP_READ    = 2'd0,
		OP_REPLACE = 2'd1,
		OP_INSERT  = 2'd2,
		OP_REMOVE  = 2'd3
	} rbv_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} rbv_status_t;

	// Command transaction
	typedef struct packed {
		rbv_op_t             opcode;
		logic [RANK_W-1:0]   rank;
		logic [DATA_W-1:0]   elem;
	} rbv_cmd_t;

	// Result transaction
	typedef struct packed {
		logic [DATA_W-1:0]   read_data;
		rbv_status_t         status;
		logic [CNT_W-1:0]    entry_count;
		logic                vacant;
	} rbv_rsp_t;

	// Broadcast from the controller to every cell; qualified by a good command
	typedef struct packed {
		logic                do_insert;
		logic                do_remove;
		logic                do_replace;
		logic [RANK_W-1:0]   rank;
		logic [DATA_W-1:0]   elem;
	} rbv_cell_ctl_t;

endpackage

>>> design/rbv_cell.sv
// One cell of the rank-addressed byte chain: holds the entry at its index.
// Depends on rbv_pkg.
module rbv_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CMP_W = 7
) (
	input  logic                      clk,
	input  rbv_pkg::rbv_cell_ctl_t    ctl,
	input  logic [rbv_pkg::DATA_W-1:0] left_data,
	input  logic [rbv_pkg::DATA_W-1:0] right_data,
	output logic [rbv_pkg::DATA_W-1:0] data,
	output logic [rbv_pkg::DATA_W-1:0] sel_data
);
	import rbv_pkg::*;

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic [DATA_W-1:0] entry_q;
	logic [CMP_W-1:0]  rank_ext;
	logic              hit;
	logic              above;

	// Position of this cell relative to the addressed rank
	assign rank_ext = CMP_W'(ctl.rank);
	assign hit      = (rank_ext == MY_IDX);
	assign above    = (rank_ext < MY_IDX);

	// Shift up on insert, shift down on remove, load on replace or insert hit
	always_ff @(posedge clk) begin
		if (ctl.do_insert && above) begin
			entry_q <= left_data;
		end else if ((ctl.do_insert || ctl.do_replace) && hit) begin
			entry_q <= ctl.elem;
		end else if (ctl.do_remove && (hit || above)) begin
			entry_q <= right_data;
		end
	end

	assign data     = entry_q;
	// Masked copy for the read OR tree
	assign sel_data = hit ? entry_q : '0;

endmodule

>>> design/rbv_ctrl.sv
// Command decode, range checks, entry count and result register.
// Depends on rbv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rbv_ctrl #(
	parameter int unsigned DEPTH = rbv_pkg::DEPTH_DEF,
	parameter int unsigned CMP_W = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  rbv_pkg::rbv_cmd_t          cmd,
	input  logic [rbv_pkg::DATA_W-1:0] rd_byte,
	output rbv_pkg::rbv_cell_ctl_t     ctl,
	output logic                       busy,
	output logic                       done,
	output rbv_pkg::rbv_rsp_t          rsp
);
	import rbv_pkg::*;

	localparam int unsigned CNT_IW = $clog2(DEPTH + 1);
	localparam logic [CNT_IW-1:0] FULL_CNT = CNT_IW'(DEPTH);

	logic [CNT_IW-1:0] count_q;
	logic [CNT_IW-1:0] count_next;
	logic              done_q;
	rbv_rsp_t          rsp_q;
	rbv_status_t       status;
	logic              accept;
	logic              rank_lt;
	logic              rank_le;
	logic              ok;
	logic [CMP_W-1:0]  rank_ext;
	logic [CMP_W-1:0]  cnt_ext;

	// One command per cycle; never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Range checks against the current count
	assign rank_ext = CMP_W'(cmd.rank);
	assign cnt_ext  = CMP_W'(count_q);
	assign rank_lt  = rank_ext < cnt_ext;
	assign rank_le  = rank_ext <= cnt_ext;

	// Status decode
	always_comb begin
		status = ST_OK;
		case (cmd.opcode)
			OP_READ, OP_REPLACE, OP_REMOVE: begin
				if (!rank_lt) status = ST_RANGE;
			end
			OP_INSERT: begin
				if (!rank_le) status = ST_RANGE;
				else if (count_q == FULL_CNT) status = ST_FULL;
			end
			default: status = ST_RANGE;
		endcase
	end

	assign ok = accept && (status == ST_OK);

	// Cell broadcast
	always_comb begin
		ctl.do_insert  = ok && (cmd.opcode == OP_INSERT);
		ctl.do_remove  = ok && (cmd.opcode == OP_REMOVE);
		ctl.do_replace = ok && (cmd.opcode == OP_REPLACE);
		ctl.rank       = cmd.rank;
		ctl.elem       = cmd.elem;
	end

	// Count after the command
	always_comb begin
		count_next = count_q;
		if (ctl.do_insert) count_next = count_q + 1'b1;
		else if (ctl.do_remove) count_next = count_q - 1'b1;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.read_data   <= (ok && cmd.opcode == OP_READ) ? rd_byte : '0;
			rsp_q.status      <= status;
			rsp_q.entry_count <= CNT_W'(count_next);
			rsp_q.vacant      <= (count_next == '0);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`RBV_ASSERT(a_count_bound, clk, arst_n, count_q <= FULL_CNT, "count above depth")
	`RBV_ASSERT(a_data_only_ok, clk, arst_n,
		done |-> (rsp.status == ST_OK || rsp.read_data == '0), "data on failed command")
	`RBV_ASSERT(a_full_only_full, clk, arst_n,
		(done && rsp.status == ST_FULL) |-> (count_q == FULL_CNT), "full status while not full")
	`RBV_NEVER(a_one_edit, clk, arst_n,
		$countones({ctl.do_insert, ctl.do_remove, ctl.do_replace}) > 1, "two edits at once")

endmodule

>>> design/rank_addressed_byte_vector_top.sv
// Top level of the rank-addressed byte vector: controller plus cell chain.
// Depends on rbv_pkg, rbv_ctrl and rbv_cell.
//
//  channel   handshake            payload
//  command   start, busy          cmd   (opcode, rank, elem)
//  result    done (one-cycle)     rsp   (read_data, status, entry_count, vacant)
//
// A command is taken on any edge with start high; busy stays low, so one
// command per cycle is sustained. Its result is on rsp with done in the
// cycle after acceptance. Insert and remove shift the cells from the
// addressed rank up in that same cycle. Reset clears the count; the
// cells are undefined until written. The receiver cannot stall results.
module rank_addressed_byte_vector_top #(
	parameter int unsigned DEPTH = rbv_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rbv_pkg::rbv_cmd_t cmd,
	output logic              busy,
	output logic              done,
	output rbv_pkg::rbv_rsp_t rsp
);
	import rbv_pkg::*;

	localparam int unsigned CNT_IW = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W  = (CNT_IW > RANK_W) ? CNT_IW : RANK_W;

	rbv_cell_ctl_t     ctl;
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] cell_sel  [DEPTH];
	logic [DATA_W-1:0] rd_byte;

	rbv_ctrl #(
		.DEPTH (DEPTH),
		.CMP_W (CMP_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.rd_byte (rd_byte),
		.ctl     (ctl),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp)
	);

	// Cell chain; each cell sees its two neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		rbv_cell #(
			.IDX   (i),
			.CMP_W (CMP_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.sel_data   (cell_sel[i])
		);
	end

	// Read path: at most one cell drives a nonzero masked byte
	always_comb begin
		rd_byte = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rd_byte = rd_byte | cell_sel[k];
		end
	end

endmodule
